>>> rtl/core/power_source_transfer_controller_top_defines.svh
// Assertion macros shared by the power source transfer controller RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef POWER_SOURCE_TRANSFER_CONTROLLER_TOP_DEFINES_SVH
`define POWER_SOURCE_TRANSFER_CONTROLLER_TOP_DEFINES_SVH

// Checked on every rising edge out of reset.
`define PSTC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define PSTC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/core/pstc_pkg.sv
// Package for the power source transfer controller: payload structs,
// mode and message codes, register indexes and reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pstc_pkg;

    localparam int ADC_BITS_DEF = 10;
    localparam int CODE_W       = 10;
    localparam int VOLT_W       = 9;
    localparam int TICK_W       = 16;
    localparam int ATT_W        = 4;
    localparam int CNT_W        = 3;
    localparam int IDX_W        = 3;
    localparam int CFG_DATA_W   = 16;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_WIND_ON     = 3'd0;
    localparam logic [IDX_W-1:0] CFG_SOLAR_ON    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_SOLAR_LOW   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_GRID_ON     = 3'd3;
    localparam logic [IDX_W-1:0] CFG_UPS_LOW     = 3'd4;
    localparam logic [IDX_W-1:0] CFG_CRANK_WAIT  = 3'd5;
    localparam logic [IDX_W-1:0] CFG_RETRY_GAP   = 3'd6;
    localparam logic [IDX_W-1:0] CFG_ATTEMPTS    = 3'd7;

    // register reset values
    localparam logic [VOLT_W-1:0] RST_WIND_ON    = 9'd11;
    localparam logic [VOLT_W-1:0] RST_SOLAR_ON   = 9'd11;
    localparam logic [VOLT_W-1:0] RST_SOLAR_LOW  = 9'd9;
    localparam logic [VOLT_W-1:0] RST_GRID_ON    = 9'd100;
    localparam logic [VOLT_W-1:0] RST_UPS_LOW    = 9'd10;
    localparam logic [TICK_W-1:0] RST_CRANK_WAIT = 16'd5000;
    localparam logic [TICK_W-1:0] RST_RETRY_GAP  = 16'd500;
    localparam logic [ATT_W-1:0]  RST_ATTEMPTS   = 4'd4;
    localparam logic [ATT_W-1:0]  MAX_ATTEMPTS   = 4'd8;

    typedef enum logic [2:0] {
        MODE_EVAL  = 3'd0,
        MODE_CRANK = 3'd1,
        MODE_GAP   = 3'd2,
        MODE_GEN   = 3'd3,
        MODE_UPS   = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        MSG_NONE  = 3'd0,
        MSG_WIND  = 3'd1,
        MSG_SOLAR = 3'd2,
        MSG_BATLO = 3'd3,
        MSG_GRID  = 3'd4,
        MSG_START = 3'd5,
        MSG_GEN   = 3'd6,
        MSG_UPS   = 3'd7
    } t_msg;

    typedef struct packed {
        logic [CODE_W-1:0] grid_code;
        logic [CODE_W-1:0] generator_code;
        logic [CODE_W-1:0] solar_code;
        logic [CODE_W-1:0] ups_code;
        logic [CODE_W-1:0] wind_code;
        logic              generator_running;
    } t_in;

    typedef struct packed {
        logic              wind_relay;
        logic              solar_relay;
        logic              grid_relay;
        logic              generator_relay;
        logic              starter_on;
        logic              generator_lamp;
        logic              ups_low_lamp;
        t_msg              message;
        logic [VOLT_W-1:0] shown_volts;
    } t_out;

    typedef struct packed {
        logic [VOLT_W-1:0] grid;
        logic [VOLT_W-1:0] gen;
        logic [VOLT_W-1:0] solar;
        logic [VOLT_W-1:0] ups;
        logic [VOLT_W-1:0] wind;
        logic              running;
    } t_volts;

    typedef struct packed {
        logic [VOLT_W-1:0] wind_on;
        logic [VOLT_W-1:0] solar_on;
        logic [VOLT_W-1:0] solar_low;
        logic [VOLT_W-1:0] grid_on;
        logic [VOLT_W-1:0] ups_low;
        logic [TICK_W-1:0] crank_wait;
        logic [TICK_W-1:0] retry_gap;
        logic [ATT_W-1:0]  start_attempts;
    } t_cfg;

endpackage

`default_nettype wire

>>> rtl/core/pstc_volts.sv
// Converter code to volts: (code * 502) >> 10 after masking to ADC_BITS.
// Depends on pstc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pstc_volts #(
    parameter int ADC_BITS = pstc_pkg::ADC_BITS_DEF
) (
    input  wire logic [pstc_pkg::CODE_W-1:0] i_code,
    output logic      [pstc_pkg::VOLT_W-1:0] o_volts
);

    localparam int PW = pstc_pkg::CODE_W + pstc_pkg::VOLT_W;

    logic [pstc_pkg::CODE_W-1:0] code_m;
    logic [PW-1:0]               prod;

    // bits at or above the converter width read as zero
    always_comb begin
        for (int b = 0; b < pstc_pkg::CODE_W; b++) begin
            code_m[b] = i_code[b] & (b < ADC_BITS);
        end
    end

    // 502 = 512 - 8 - 2; the top bits never pass 501
    assign prod = {code_m, 9'd0} - {6'd0, code_m, 3'd0} - {8'd0, code_m, 1'b0};
    assign o_volts = prod[PW-1:pstc_pkg::CODE_W];

endmodule

`default_nettype wire

>>> rtl/core/pstc_cfg.sv
// Configuration register file of the transfer controller, write only.
// Depends on pstc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pstc_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_we,
    input  wire logic [pstc_pkg::IDX_W-1:0]      i_idx,
    input  wire logic [pstc_pkg::CFG_DATA_W-1:0] i_data,
    output pstc_pkg::t_cfg                       o_cfg
);

    pstc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wind_on        <= pstc_pkg::RST_WIND_ON;
            r_cfg.solar_on       <= pstc_pkg::RST_SOLAR_ON;
            r_cfg.solar_low      <= pstc_pkg::RST_SOLAR_LOW;
            r_cfg.grid_on        <= pstc_pkg::RST_GRID_ON;
            r_cfg.ups_low        <= pstc_pkg::RST_UPS_LOW;
            r_cfg.crank_wait     <= pstc_pkg::RST_CRANK_WAIT;
            r_cfg.retry_gap      <= pstc_pkg::RST_RETRY_GAP;
            r_cfg.start_attempts <= pstc_pkg::RST_ATTEMPTS;
        end else if (i_we) begin
            unique case (i_idx)
                pstc_pkg::CFG_WIND_ON:    r_cfg.wind_on   <= i_data[pstc_pkg::VOLT_W-1:0];
                pstc_pkg::CFG_SOLAR_ON:   r_cfg.solar_on  <= i_data[pstc_pkg::VOLT_W-1:0];
                pstc_pkg::CFG_SOLAR_LOW:  r_cfg.solar_low <= i_data[pstc_pkg::VOLT_W-1:0];
                pstc_pkg::CFG_GRID_ON:    r_cfg.grid_on   <= i_data[pstc_pkg::VOLT_W-1:0];
                pstc_pkg::CFG_UPS_LOW:    r_cfg.ups_low   <= i_data[pstc_pkg::VOLT_W-1:0];
                pstc_pkg::CFG_CRANK_WAIT: r_cfg.crank_wait <= i_data[pstc_pkg::TICK_W-1:0];
                pstc_pkg::CFG_RETRY_GAP:  r_cfg.retry_gap  <= i_data[pstc_pkg::TICK_W-1:0];
                pstc_pkg::CFG_ATTEMPTS:   r_cfg.start_attempts <= i_data[pstc_pkg::ATT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> rtl/core/pstc_ctrl.sv
// Transfer state machine: source priority, generator start sequence,
// generator and UPS hold modes. Depends on pstc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pstc_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire pstc_pkg::t_volts i_volts,
    input  wire pstc_pkg::t_cfg   i_cfg,
    output pstc_pkg::t_out        o_res
);

    typedef enum logic [2:0] {
        ACT_EVAL,
        ACT_CRANK_ON,
        ACT_CRANK_FAIL,
        ACT_GAP_WAIT,
        ACT_NEXT_TRY,
        ACT_GEN,
        ACT_UPS
    } t_act;

    pstc_pkg::t_mode                r_mode, n_mode;
    logic [pstc_pkg::CNT_W-1:0]     r_att, n_att;
    logic [pstc_pkg::TICK_W-1:0]    r_timer, n_timer;
    logic                           r_latch, n_latch;

    t_act                           act;
    logic [pstc_pkg::TICK_W-1:0]    timer_inc;
    logic [pstc_pkg::TICK_W-1:0]    wait_ticks;
    logic [pstc_pkg::ATT_W-1:0]     attempts;
    logic [pstc_pkg::ATT_W-1:0]     att_inc;
    logic wind_ok, solar_ok, solar_low_ok, grid_ok, any_src, back, ups_low;

    assign wind_ok      = i_volts.wind  >= i_cfg.wind_on;
    assign solar_ok     = i_volts.solar >= i_cfg.solar_on;
    assign solar_low_ok = i_volts.solar >= i_cfg.solar_low;
    assign grid_ok      = i_volts.grid  >= i_cfg.grid_on;
    assign any_src      = wind_ok | solar_ok | solar_low_ok | grid_ok;
    assign back         = wind_ok | solar_ok | grid_ok;
    assign ups_low      = i_volts.ups < i_cfg.ups_low;

    assign timer_inc  = r_timer + 1'b1;
    assign wait_ticks = (i_cfg.crank_wait == '0) ? {{(pstc_pkg::TICK_W-1){1'b0}}, 1'b1}
                                                 : i_cfg.crank_wait;
    assign att_inc    = {1'b0, r_att} + 1'b1;

    always_comb begin
        priority if (i_cfg.start_attempts == '0) begin
            attempts = {{(pstc_pkg::ATT_W-1){1'b0}}, 1'b1};
        end else if (i_cfg.start_attempts > pstc_pkg::MAX_ATTEMPTS) begin
            attempts = pstc_pkg::MAX_ATTEMPTS;
        end else begin
            attempts = i_cfg.start_attempts;
        end
    end

    // what this tick does
    always_comb begin
        unique case (r_mode)
            pstc_pkg::MODE_CRANK: begin
                priority if (timer_inc < wait_ticks) act = ACT_CRANK_ON;
                else if (i_volts.running)            act = ACT_GEN;
                else                                 act = ACT_CRANK_FAIL;
            end
            pstc_pkg::MODE_GAP: begin
                priority if (timer_inc < i_cfg.retry_gap) act = ACT_GAP_WAIT;
                else if (att_inc >= attempts)             act = ACT_UPS;
                else if (back)                            act = ACT_EVAL;
                else                                      act = ACT_NEXT_TRY;
            end
            pstc_pkg::MODE_GEN: begin
                priority if (back)          act = ACT_EVAL;
                else if (!i_volts.running)  act = ACT_UPS;
                else                        act = ACT_GEN;
            end
            pstc_pkg::MODE_UPS: begin
                act = back ? ACT_EVAL : ACT_UPS;
            end
            default: act = ACT_EVAL;
        endcase
    end

    // next state
    always_comb begin
        n_mode  = r_mode;
        n_att   = r_att;
        n_timer = r_timer;
        n_latch = r_latch;
        unique case (act)
            ACT_EVAL: begin
                // latch is only ever set in UPS mode, which leaves through here
                n_latch = 1'b0;
                if (any_src) begin
                    n_mode = pstc_pkg::MODE_EVAL;
                end else begin
                    n_mode  = pstc_pkg::MODE_CRANK;
                    n_att   = '0;
                    n_timer = '0;
                end
            end
            ACT_CRANK_ON, ACT_GAP_WAIT: n_timer = timer_inc;
            ACT_CRANK_FAIL: begin
                n_mode  = pstc_pkg::MODE_GAP;
                n_timer = '0;
            end
            ACT_NEXT_TRY: begin
                n_mode  = pstc_pkg::MODE_CRANK;
                n_att   = att_inc[pstc_pkg::CNT_W-1:0];
                n_timer = '0;
            end
            ACT_GEN: n_mode = pstc_pkg::MODE_GEN;
            ACT_UPS: begin
                n_mode  = pstc_pkg::MODE_UPS;
                n_latch = r_latch | ups_low;
            end
            default: ;
        endcase
    end

    // result of this tick
    always_comb begin
        o_res = '0;
        o_res.message = pstc_pkg::MSG_START;
        unique case (act)
            ACT_EVAL: begin
                priority if (wind_ok) begin
                    o_res.wind_relay  = 1'b1;
                    o_res.message     = pstc_pkg::MSG_WIND;
                    o_res.shown_volts = i_volts.wind;
                end else if (solar_ok) begin
                    o_res.solar_relay = 1'b1;
                    o_res.message     = pstc_pkg::MSG_SOLAR;
                    o_res.shown_volts = i_volts.solar;
                end else if (solar_low_ok) begin
                    o_res.solar_relay = 1'b1;
                    o_res.message     = pstc_pkg::MSG_BATLO;
                    o_res.shown_volts = i_volts.solar;
                end else if (grid_ok) begin
                    o_res.grid_relay  = 1'b1;
                    o_res.message     = pstc_pkg::MSG_GRID;
                    o_res.shown_volts = i_volts.grid;
                end else begin
                    o_res.starter_on     = 1'b1;
                    o_res.generator_lamp = 1'b1;
                end
            end
            ACT_CRANK_ON, ACT_NEXT_TRY: begin
                o_res.starter_on     = 1'b1;
                o_res.generator_lamp = 1'b1;
            end
            ACT_CRANK_FAIL, ACT_GAP_WAIT: o_res.generator_lamp = 1'b1;
            ACT_GEN: begin
                o_res.generator_relay = 1'b1;
                o_res.generator_lamp  = 1'b1;
                o_res.message         = pstc_pkg::MSG_GEN;
                o_res.shown_volts     = i_volts.gen;
            end
            ACT_UPS: begin
                o_res.message     = pstc_pkg::MSG_UPS;
                o_res.shown_volts = i_volts.ups;
            end
            default: ;
        endcase
        o_res.ups_low_lamp = n_latch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= pstc_pkg::MODE_EVAL;
            r_att   <= '0;
            r_timer <= '0;
            r_latch <= 1'b0;
        end else if (i_adv) begin
            r_mode  <= n_mode;
            r_att   <= n_att;
            r_timer <= n_timer;
            r_latch <= n_latch;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/power_source_transfer_controller_top.sv
// Top level of the power source transfer controller: request channels,
// input and result registers. Depends on pstc_pkg, pstc_volts, pstc_cfg, pstc_ctrl.
`timescale 1ns / 1ps
`default_nettype none

//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in_data  (t_in)
//  out     | output    | o_out_valid / i_out_stall  | o_out_data (t_out)
//  cfg     | input     | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
//  One request per cycle sustained while i_out_stall is low; a request's
//  result passes the volts register, then the result register.
//  The mode, attempt and timer registers in pstc_ctrl feed back through
//  combinational next-state logic only, which sets the one-per-cycle figure.
//  Reset (synchronous, active low) restores register defaults and the
//  priority evaluation mode; no clearing pass.
//  A stalled result holds; one more request can wait in the volts register.

module power_source_transfer_controller_top #(
    parameter int ADC_BITS = pstc_pkg::ADC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire pstc_pkg::t_in                   i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output pstc_pkg::t_out                       o_out_data,
    input  wire logic                            i_cfg_we,
    input  wire logic [pstc_pkg::IDX_W-1:0]      i_cfg_idx,
    input  wire logic [pstc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    pstc_pkg::t_volts volts_in;
    pstc_pkg::t_volts r_volts;
    logic             r_s1_valid;
    pstc_pkg::t_out   r_out;
    logic             r_out_valid;
    pstc_pkg::t_out   res;
    pstc_pkg::t_cfg   cfg;
    logic             adv;
    logic             in_acc;

    // code to volts ahead of the input register
    pstc_volts #(.ADC_BITS(ADC_BITS)) u_v_grid (
        .i_code (i_in_data.grid_code),      .o_volts(volts_in.grid));
    pstc_volts #(.ADC_BITS(ADC_BITS)) u_v_gen (
        .i_code (i_in_data.generator_code), .o_volts(volts_in.gen));
    pstc_volts #(.ADC_BITS(ADC_BITS)) u_v_solar (
        .i_code (i_in_data.solar_code),     .o_volts(volts_in.solar));
    pstc_volts #(.ADC_BITS(ADC_BITS)) u_v_ups (
        .i_code (i_in_data.ups_code),       .o_volts(volts_in.ups));
    pstc_volts #(.ADC_BITS(ADC_BITS)) u_v_wind (
        .i_code (i_in_data.wind_code),      .o_volts(volts_in.wind));
    assign volts_in.running = i_in_data.generator_running;

    pstc_cfg u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (i_cfg_we),
        .i_idx  (i_cfg_idx),
        .i_data (i_cfg_data),
        .o_cfg  (cfg)
    );

    // stage 1 moves into the result register when that is free or draining
    assign adv        = r_s1_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_s1_valid & ~adv;
    assign in_acc     = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc | (r_s1_valid & ~adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_volts <= volts_in;
        end
    end

    pstc_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (adv),
        .i_volts(r_volts),
        .i_cfg  (cfg),
        .o_res  (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= adv | (r_out_valid & i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // terms for the checks below
    logic [3:0] out_relays;
    logic       out_starter, out_low_lamp, out_idle;
    logic       msg_set, start_shown, ups_shown;

    assign out_relays   = {o_out_data.wind_relay, o_out_data.solar_relay,
                           o_out_data.grid_relay, o_out_data.generator_relay};
    assign out_starter  = o_out_valid & o_out_data.starter_on;
    assign out_low_lamp = o_out_valid & o_out_data.ups_low_lamp;
    assign out_idle     = ~o_out_valid & ~o_in_stall;
    assign msg_set      = o_out_data.message != pstc_pkg::MSG_NONE;
    assign start_shown  = (o_out_data.message == pstc_pkg::MSG_START)
                        & o_out_data.generator_lamp;
    assign ups_shown    = o_out_data.message == pstc_pkg::MSG_UPS;

    `include "power_source_transfer_controller_top_defines.svh"

    `PSTC_ASSERT(a_adv_shows, adv |=> o_out_valid, "advanced request not presented")
    `PSTC_ASSERT(a_one_relay, o_out_valid |-> $onehot0(out_relays), "more than one relay closed")
    `PSTC_ASSERT(a_msg_set, o_out_valid |-> msg_set, "empty message")
    `PSTC_ASSERT(a_starter_msg, out_starter |-> start_shown, "starter without start message")
    `PSTC_ASSERT(a_low_lamp_ups, out_low_lamp |-> ups_shown, "low lamp outside UPS mode")
    `PSTC_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> out_idle, "not idle after reset")

endmodule

`default_nettype wire
